/* rtl/core/mbe_pkg.sv */
package mbe_pkg;

    // fixed-point layout of c and z
    localparam int FRAC = 28;

    // register indexes on the configuration port
    localparam logic [2:0] REG_REAL_LEFT  = 3'd0;
    localparam logic [2:0] REG_IMAG_TOP   = 3'd1;
    localparam logic [2:0] REG_STEP_REAL  = 3'd2;
    localparam logic [2:0] REG_STEP_IMAG  = 3'd3;
    localparam logic [2:0] REG_ITER_LEVEL = 3'd4;
    localparam logic [2:0] REG_COLOR_MODE = 3'd5;

    // color modes
    localparam logic [1:0] MODE_RAMP  = 2'd0;
    localparam logic [1:0] MODE_BASE1 = 2'd1;
    localparam logic [1:0] MODE_BASE2 = 2'd2;

    // color constants
    localparam logic [31:0] COLOR_BASE1 = 32'h0070_2a42;
    localparam logic [31:0] COLOR_WHITE = 32'h00ff_ffff;

    // reset values of the registers
    localparam logic [31:0] RST_REAL_LEFT = 32'he000_0000;
    localparam logic [31:0] RST_IMAG_TOP  = 32'h1000_0000;
    localparam logic [27:0] RST_STEP_REAL = 28'd786432;
    localparam logic [27:0] RST_STEP_IMAG = 28'd524288;

    // one input word
    typedef struct packed {
        logic [9:0] pixel_col;
        logic [9:0] pixel_row;
    } pix_t;

    // one result word
    typedef struct packed {
        logic [11:0] escape_count;
        logic [31:0] pixel_color;
        logic        pixel_written;
    } res_t;

    // register file contents handed to the core
    typedef struct packed {
        logic signed [31:0] real_left;
        logic signed [31:0] imag_top;
        logic [27:0]        step_real;
        logic [27:0]        step_imag;
        logic [5:0]         iter_level;
        logic [1:0]         color_mode;
    } cfg_t;

endpackage

/* rtl/core/mbe_cfg.sv */
module mbe_cfg (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [4:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready,
    output mbe_pkg::cfg_t cfg
);
    import mbe_pkg::*;

    cfg_t        cfg_reg;
    logic        wr_en;
    logic [2:0]  idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = paddr[4:2];
    assign cfg    = cfg_reg;

    // register writes, access phase
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.real_left  <= RST_REAL_LEFT;
            cfg_reg.imag_top   <= RST_IMAG_TOP;
            cfg_reg.step_real  <= RST_STEP_REAL;
            cfg_reg.step_imag  <= RST_STEP_IMAG;
            cfg_reg.iter_level <= 6'd0;
            cfg_reg.color_mode <= MODE_RAMP;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_REAL_LEFT:  cfg_reg.real_left  <= pwdata;
                REG_IMAG_TOP:   cfg_reg.imag_top   <= pwdata;
                REG_STEP_REAL:  cfg_reg.step_real  <= pwdata[27:0];
                REG_STEP_IMAG:  cfg_reg.step_imag  <= pwdata[27:0];
                REG_ITER_LEVEL: cfg_reg.iter_level <= pwdata[5:0];
                REG_COLOR_MODE: cfg_reg.color_mode <= pwdata[1:0];
                default: ;
            endcase
        end
    end

    // read mux
    always_comb
    begin
        unique case (idx)
            REG_REAL_LEFT:  prdata = cfg_reg.real_left;
            REG_IMAG_TOP:   prdata = cfg_reg.imag_top;
            REG_STEP_REAL:  prdata = {4'd0, cfg_reg.step_real};
            REG_STEP_IMAG:  prdata = {4'd0, cfg_reg.step_imag};
            REG_ITER_LEVEL: prdata = {26'd0, cfg_reg.iter_level};
            REG_COLOR_MODE: prdata = {30'd0, cfg_reg.color_mode};
            default:        prdata = 32'd0;
        endcase
    end

endmodule

/* rtl/core/mandelbrot_escape_pixel_top.sv */
// Escape-time engine: one pixel word at a time on a single shared 33x33 multiplier.
// Sequence: setup states (CRE, CIM, CIMW), then per iteration check with cross product,
// update, two squares and escape test, a final check at the limit, and the color
// states (CSQ, CMUL, OUT). A new word is taken only when the sequencer is idle;
// a stalled output holds the sequencer; out-of-image pixels go from idle to output.
// Reset (rst_n, async low) loads register defaults and idles the sequencer.
module mandelbrot_escape_pixel_top #(
    parameter int COLUMNS   = 1024,
    parameter int ROWS      = 1024,
    parameter int MAX_LEVEL = 40
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [4:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready,
    input  logic          pix_valid,
    output logic          pix_ready,
    input  mbe_pkg::pix_t pix,
    output logic          res_valid,
    input  logic          res_ready,
    output mbe_pkg::res_t res
);
    import mbe_pkg::*;

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_CRE  = 4'd1;
    localparam logic [3:0] ST_CIM  = 4'd2;
    localparam logic [3:0] ST_CIMW = 4'd3;
    localparam logic [3:0] ST_CHK  = 4'd4;
    localparam logic [3:0] ST_UPD  = 4'd5;
    localparam logic [3:0] ST_SQR  = 4'd6;
    localparam logic [3:0] ST_SQI  = 4'd7;
    localparam logic [3:0] ST_ESC  = 4'd8;
    localparam logic [3:0] ST_CSQ  = 4'd9;
    localparam logic [3:0] ST_CMUL = 4'd10;
    localparam logic [3:0] ST_OUT  = 4'd11;

    localparam logic signed [34:0] TWO_Q28  = 35'sd1 <<< (FRAC + 1);
    localparam logic signed [65:0] FOUR_Q56 = 66'sd1 <<< (2 * FRAC + 2);

    cfg_t cfg;

    mbe_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    logic [3:0]         state_reg, state_next;
    logic [9:0]         col_reg, row_reg;
    logic               inside_reg;
    logic signed [31:0] cre_reg, cim_reg;
    logic signed [32:0] zre_reg, zim_reg;
    logic signed [65:0] sq_re_reg, sq_im_reg;
    logic signed [65:0] mul_reg;
    logic signed [32:0] mul_a, mul_b;
    logic [11:0]        count_reg;
    logic               res_valid_reg;
    res_t               res_reg;

    logic [5:0]         level_eff;
    logic [11:0]        limit;
    logic               pix_inside;
    logic signed [39:0] cre_sum, cim_sum;
    logic signed [65:0] diff;
    logic signed [34:0] nre, nim;
    logic               bound_esc;
    logic               sum_esc;
    logic               out_free;
    logic [31:0]        base_color;
    res_t               res_new;

    // saturate a 40-bit sum to signed 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
        logic signed [31:0] r;
        if (v > 40'sh00_7fff_ffff)
            r = 32'sh7fff_ffff;
        else if (v < -40'sh00_8000_0000)
            r = -32'sh8000_0000;
        else
            r = v[31:0];
        return r;
    endfunction

    // iteration limit
    assign level_eff = (int'(cfg.iter_level) > MAX_LEVEL) ? 6'(MAX_LEVEL) : cfg.iter_level;
    assign limit     = 12'd50 + 12'(level_eff) * 12'd50;

    assign pix_inside = ({3'd0, pix.pixel_col} < 13'(COLUMNS)) &&
                        ({3'd0, pix.pixel_row} < 13'(ROWS));

    assign pix_ready = (state_reg == ST_IDLE);
    assign out_free  = !res_valid_reg || res_ready;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    // c from corner and step products
    assign cre_sum = 40'(cfg.real_left) + mul_reg[39:0];
    assign cim_sum = 40'(cfg.imag_top) - mul_reg[39:0];

    // z update: floor shifts, then add c
    assign diff = sq_re_reg - sq_im_reg;
    assign nre  = 35'(diff >>> FRAC) + 35'(cre_reg);
    assign nim  = 35'(mul_reg >>> (FRAC - 1)) + 35'(cim_reg);
    assign bound_esc = (nre > TWO_Q28) || (nre < -TWO_Q28) ||
                       (nim > TWO_Q28) || (nim < -TWO_Q28);
    assign sum_esc   = (sq_re_reg + mul_reg) > FOUR_Q56;

    // shared multiplier operand select
    always_comb
    begin
        mul_a = zre_reg;
        mul_b = zim_reg;
        unique case (state_reg)
            ST_CRE:
            begin
                mul_a = {5'd0, cfg.step_real};
                mul_b = {23'd0, col_reg};
            end
            ST_CIM:
            begin
                mul_a = {5'd0, cfg.step_imag};
                mul_b = {23'd0, row_reg};
            end
            ST_SQR:
            begin
                mul_a = zre_reg;
                mul_b = zre_reg;
            end
            ST_SQI:
            begin
                mul_a = zim_reg;
                mul_b = zim_reg;
            end
            ST_CSQ:
            begin
                mul_a = {21'd0, count_reg};
                mul_b = {21'd0, count_reg};
            end
            ST_CMUL:
            begin
                if (cfg.color_mode == MODE_RAMP)
                begin
                    mul_a = {21'd0, count_reg};
                    mul_b = 33'sd50;
                end
                else
                begin
                    mul_a = mul_reg[32:0];
                    mul_b = 33'sd300;
                end
            end
            default: ;
        endcase
    end

    // product register, held while the result waits for the output
    always_ff @(posedge clk)
    begin
        if (state_reg != ST_OUT)
            mul_reg <= mul_a * mul_b;
    end

    // result formatting
    assign base_color = (cfg.color_mode == MODE_BASE1) ? COLOR_BASE1 : COLOR_WHITE;

    always_comb
    begin
        res_new.escape_count  = count_reg;
        res_new.pixel_color   = 32'd0;
        res_new.pixel_written = 1'b0;
        if (inside_reg)
        begin
            case (cfg.color_mode) inside
                MODE_RAMP:
                begin
                    if (count_reg == limit)
                    begin
                        res_new.pixel_color   = COLOR_WHITE;
                        res_new.pixel_written = 1'b1;
                    end
                    else if (count_reg > 12'd15)
                    begin
                        res_new.pixel_color   = COLOR_WHITE + mul_reg[31:0];
                        res_new.pixel_written = 1'b1;
                    end
                end
                MODE_BASE1, MODE_BASE2:
                begin
                    res_new.pixel_color   = (count_reg == limit) ? base_color
                                                                 : base_color + mul_reg[31:0];
                    res_new.pixel_written = 1'b1;
                end
                default: ;
            endcase
        end
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (pix_valid) state_next = pix_inside ? ST_CRE : ST_OUT;
            ST_CRE:  state_next = ST_CIM;
            ST_CIM:  state_next = ST_CIMW;
            ST_CIMW: state_next = ST_CHK;
            ST_CHK:  state_next = (count_reg == limit) ? ST_CSQ : ST_UPD;
            ST_UPD:  state_next = bound_esc ? ST_CSQ : ST_SQR;
            ST_SQR:  state_next = ST_SQI;
            ST_SQI:  state_next = ST_ESC;
            ST_ESC:  state_next = sum_esc ? ST_CSQ : ST_CHK;
            ST_CSQ:  state_next = ST_CMUL;
            ST_CMUL: state_next = ST_OUT;
            ST_OUT:  if (out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_OUT && out_free)
                res_valid_reg <= 1'b1;
            else if (res_ready)
                res_valid_reg <= 1'b0;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                if (pix_valid)
                begin
                    col_reg    <= pix.pixel_col;
                    row_reg    <= pix.pixel_row;
                    inside_reg <= pix_inside;
                    count_reg  <= 12'd0;
                end
            end
            ST_CIM:
            begin
                cre_reg <= sat32(cre_sum);
            end
            ST_CIMW:
            begin
                cim_reg   <= sat32(cim_sum);
                zre_reg   <= 33'sd0;
                zim_reg   <= 33'sd0;
                sq_re_reg <= 66'sd0;
                sq_im_reg <= 66'sd0;
            end
            ST_UPD:
            begin
                zre_reg <= nre[32:0];
                zim_reg <= nim[32:0];
            end
            ST_SQI:
            begin
                sq_re_reg <= mul_reg;
            end
            ST_ESC:
            begin
                sq_im_reg <= mul_reg;
                if (!sum_esc)
                    count_reg <= count_reg + 12'd1;
            end
            ST_OUT:
            begin
                if (out_free)
                    res_reg <= res_new;
            end
            default: ;
        endcase
    end

endmodule
